/* hw/rtl/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg - timer bank shared definitions
// Field widths, codes and the command/status bundles between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int TIMER_W = 15;
	localparam int PULSE_W = 7;
	localparam int PRE_W   = 4;
	localparam int EN_W    = 16;
	localparam int IDX_W   = 4;

	localparam logic [TIMER_W-1:0] TIMER_MAX = 15'd32767;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 7'd127;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_READ = 1'b1;
	localparam logic BANK_FAST = 1'b0;
	localparam logic BANK_SLOW = 1'b1;

	typedef struct packed {
		logic accept;
		logic walk_go;
		logic walk_bank;
		logic rd_go;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic fire_fast;
		logic fire_slow;
		logic walk_done;
		logic out_free;
	} stat_t;

endpackage

/* hw/rtl/ptb_ram.sv */
// ----------------------------------------------------------------------------
// ptb_ram - generic simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module ptb_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/ptb_ctrl.sv */
// ----------------------------------------------------------------------------
// ptb_ctrl - timer bank sequencer
// Takes a word, runs the fast and slow bank walks as the prescalers demand,
// then reads the selected timer and hands the result to the output register.
// ----------------------------------------------------------------------------
module ptb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ptb_pkg::stat_t stat,
	output ptb_pkg::cmd_t  cmd
);
	import ptb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_DISPATCH  = 6'b000010,
		ST_WALK_FAST = 6'b000100,
		ST_WALK_SLOW = 6'b001000,
		ST_READ      = 6'b010000,
		ST_RESULT    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.fire_fast) begin
					cmd.walk_go   = 1'b1;
					cmd.walk_bank = BANK_FAST;
					state_d       = ST_WALK_FAST;
				end else if (stat.fire_slow) begin
					cmd.walk_go   = 1'b1;
					cmd.walk_bank = BANK_SLOW;
					state_d       = ST_WALK_SLOW;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_WALK_FAST: begin
				if (stat.walk_done) begin
					if (stat.fire_slow) begin
						cmd.walk_go   = 1'b1;
						cmd.walk_bank = BANK_SLOW;
						state_d       = ST_WALK_SLOW;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_WALK_SLOW: begin
				if (stat.walk_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_go = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		stat.walk_done |-> (state_q == ST_WALK_FAST || state_q == ST_WALK_SLOW))
		else $error("walk completion outside a walk");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over a waiting word");

	a_go_walks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_go |=> (state_q == ST_WALK_FAST || state_q == ST_WALK_SLOW))
		else $error("walk started without walk state");

endmodule

/* hw/rtl/ptb_datapath.sv */
// ----------------------------------------------------------------------------
// ptb_datapath - timer bank datapath
// Prescalers, pulse counters, the two timer RAMs with their valid bits,
// the entry walker and the output register.
// ----------------------------------------------------------------------------
module ptb_datapath #(
	parameter int FAST_TIMERS = 16,
	parameter int SLOW_TIMERS = 16,
	parameter int PRESCALE    = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptb_pkg::cmd_t                 cmd,
	output ptb_pkg::stat_t                stat,
	input  logic                          in_mode,
	input  logic [ptb_pkg::EN_W-1:0]      in_fast_en,
	input  logic [ptb_pkg::EN_W-1:0]      in_slow_en,
	input  logic                          in_bank,
	input  logic [ptb_pkg::IDX_W-1:0]     in_index,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ptb_pkg::TIMER_W-1:0]   read_value,
	output logic [ptb_pkg::PULSE_W-1:0]   pulses_10ms,
	output logic [ptb_pkg::PULSE_W-1:0]   pulses_100ms,
	output logic [ptb_pkg::PULSE_W-1:0]   pulses_1000ms
);
	import ptb_pkg::*;

	localparam int AWF  = (FAST_TIMERS > 1) ? $clog2(FAST_TIMERS) : 1;
	localparam int AWS  = (SLOW_TIMERS > 1) ? $clog2(SLOW_TIMERS) : 1;
	localparam int NMAX = (FAST_TIMERS > SLOW_TIMERS) ? FAST_TIMERS : SLOW_TIMERS;
	localparam int CW   = (NMAX > 1) ? $clog2(NMAX) : 1;
	localparam logic [PRE_W-1:0] PRE = PRE_W'(PRESCALE);

	// prescalers and pulse counters
	logic [PRE_W-1:0]   ms_q, ten_q, hun_q;
	logic [PULSE_W-1:0] p10_q, p100_q, p1000_q;
	logic               fire_fast_q, fire_slow_q;
	logic               f10, f100, f1000;
	logic [PRE_W-1:0]   ten_inc, hun_inc;

	always_comb begin
		f10     = (ms_q >= PRE);
		ten_inc = f10 ? ten_q + 1'b1 : ten_q;
		f100    = (ten_inc >= PRE);
		hun_inc = f100 ? hun_q + 1'b1 : hun_q;
		f1000   = (hun_inc >= PRE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q        <= '0;
			ten_q       <= '0;
			hun_q       <= '0;
			p10_q       <= '0;
			p100_q      <= '0;
			p1000_q     <= '0;
			fire_fast_q <= 1'b0;
			fire_slow_q <= 1'b0;
		end else if (cmd.accept) begin
			if (in_mode == MODE_TICK) begin
				ms_q        <= f10 ? PRE_W'(1) : ms_q + 1'b1;
				ten_q       <= f100 ? '0 : ten_inc;
				hun_q       <= f1000 ? '0 : hun_inc;
				fire_fast_q <= f10;
				fire_slow_q <= f100;
				if (f10 && p10_q != PULSE_MAX) begin
					p10_q <= p10_q + 1'b1;
				end
				if (f100 && p100_q != PULSE_MAX) begin
					p100_q <= p100_q + 1'b1;
				end
				if (f1000 && p1000_q != PULSE_MAX) begin
					p1000_q <= p1000_q + 1'b1;
				end
			end else begin
				fire_fast_q <= 1'b0;
				fire_slow_q <= 1'b0;
			end
		end
	end

	// latched word
	logic [EN_W-1:0]  fast_en_q, slow_en_q;
	logic             rbank_q;
	logic [IDX_W-1:0] ridx_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fast_en_q <= in_fast_en;
			slow_en_q <= in_slow_en;
			rbank_q   <= in_bank;
			ridx_q    <= in_index;
		end
	end

	// entry walker: issue a read, then update the entry and write it back from the registered read data
	logic          iss_q, wbank_q;
	logic [CW-1:0] cnt_q;
	logic          last_c, en_c;
	logic [7:0]    cnt_ext;
	logic          wr_v_s1, wlast_s1, wen_s1, wbank_s1;
	logic [CW-1:0] waddr_s1;

	always_comb begin
		cnt_ext = 8'(cnt_q);
		last_c  = (wbank_q == BANK_SLOW) ? (cnt_q == CW'(SLOW_TIMERS - 1))
		                                 : (cnt_q == CW'(FAST_TIMERS - 1));
		en_c    = (cnt_ext < 8'd16) &&
		          ((wbank_q == BANK_SLOW) ? slow_en_q[cnt_ext[3:0]]
		                                  : fast_en_q[cnt_ext[3:0]]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= 1'b0;
			cnt_q   <= '0;
			wbank_q <= BANK_FAST;
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= iss_q;
			if (cmd.walk_go) begin
				iss_q   <= 1'b1;
				cnt_q   <= '0;
				wbank_q <= cmd.walk_bank;
			end else if (iss_q) begin
				if (last_c) begin
					iss_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= cnt_q;
		wlast_s1 <= last_c;
		wen_s1   <= en_c;
		wbank_s1 <= wbank_q;
	end

	// timer RAMs
	logic [7:0]         ridx_ext;
	logic               rng_c;
	logic               f_rd_en, s_rd_en, f_wr_en, s_wr_en;
	logic [AWF-1:0]     f_rd_addr;
	logic [AWS-1:0]     s_rd_addr;
	logic [TIMER_W-1:0] f_rdata, s_rdata, old_c, new_c;
	logic [FAST_TIMERS-1:0] fv_q;
	logic [SLOW_TIMERS-1:0] sv_q;
	logic               fv_s1, sv_s1, rng_s1;

	always_comb begin
		ridx_ext  = 8'(ridx_q);
		rng_c     = (rbank_q == BANK_SLOW) ? (ridx_ext < 8'(SLOW_TIMERS))
		                                   : (ridx_ext < 8'(FAST_TIMERS));
		f_rd_en   = (iss_q && wbank_q == BANK_FAST) || (cmd.rd_go && rbank_q == BANK_FAST);
		s_rd_en   = (iss_q && wbank_q == BANK_SLOW) || (cmd.rd_go && rbank_q == BANK_SLOW);
		f_rd_addr = iss_q ? cnt_q[AWF-1:0] : ridx_ext[AWF-1:0];
		s_rd_addr = iss_q ? cnt_q[AWS-1:0] : ridx_ext[AWS-1:0];
		f_wr_en   = wr_v_s1 && wbank_s1 == BANK_FAST;
		s_wr_en   = wr_v_s1 && wbank_s1 == BANK_SLOW;
		old_c     = (wbank_s1 == BANK_SLOW) ? (sv_s1 ? s_rdata : '0)
		                                    : (fv_s1 ? f_rdata : '0);
		if (!wen_s1) begin
			new_c = '0;
		end else if (old_c != TIMER_MAX) begin
			new_c = old_c + 1'b1;
		end else begin
			new_c = old_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
			sv_q <= '0;
		end else begin
			if (f_wr_en) begin
				fv_q[waddr_s1[AWF-1:0]] <= 1'b1;
			end
			if (s_wr_en) begin
				sv_q[waddr_s1[AWS-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (f_rd_en) begin
			fv_s1 <= fv_q[f_rd_addr];
		end
		if (s_rd_en) begin
			sv_s1 <= sv_q[s_rd_addr];
		end
		if (cmd.rd_go) begin
			rng_s1 <= rng_c;
		end
	end

	ptb_ram #(.WIDTH(TIMER_W), .DEPTH(FAST_TIMERS)) u_fast_ram (
		.clk     (clk),
		.wr_en   (f_wr_en),
		.wr_addr (waddr_s1[AWF-1:0]),
		.wr_data (new_c),
		.rd_en   (f_rd_en),
		.rd_addr (f_rd_addr),
		.rd_data (f_rdata)
	);

	ptb_ram #(.WIDTH(TIMER_W), .DEPTH(SLOW_TIMERS)) u_slow_ram (
		.clk     (clk),
		.wr_en   (s_wr_en),
		.wr_addr (waddr_s1[AWS-1:0]),
		.wr_data (new_c),
		.rd_en   (s_rd_en),
		.rd_addr (s_rd_addr),
		.rd_data (s_rdata)
	);

	// output register
	logic               m_valid_q;
	logic [TIMER_W-1:0] val_c;

	always_comb begin
		if (!rng_s1) begin
			val_c = '0;
		end else if (rbank_q == BANK_SLOW) begin
			val_c = sv_s1 ? s_rdata : '0;
		end else begin
			val_c = fv_s1 ? f_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_value    <= val_c;
			pulses_10ms   <= p10_q;
			pulses_100ms  <= p100_q;
			pulses_1000ms <= p1000_q;
		end
	end

	assign m_tvalid       = m_valid_q;
	assign stat.fire_fast = fire_fast_q;
	assign stat.fire_slow = fire_slow_q;
	assign stat.walk_done = wr_v_s1 && wlast_s1;
	assign stat.out_free  = !m_valid_q || m_tready;

endmodule

/* hw/rtl/plc_timer_bank.sv */
// ----------------------------------------------------------------------------
// plc_timer_bank - soft-PLC on-delay timer bank
// 1 ms tick words drive cascaded prescalers and the 10 ms / 100 ms timer
// banks; every word returns one timer value and the pulse counts.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_*      in   tuser: mode; tdata: fast_enables, slow_enables, read_bank, read_index
//  m_*      out  tdata: read_value, pulses_10ms, pulses_100ms, pulses_1000ms
//
//  A 10 ms pass adds a walk of the fast bank and a 100 ms pass a walk of the
//  slow bank, one entry a cycle.
//  Reset clears prescalers, pulse counters and the per-entry valid bits.
//  A waiting result does not block the next word until its own result is due.
// ----------------------------------------------------------------------------
module plc_timer_bank #(
	parameter int FAST_TIMERS = 16,
	parameter int SLOW_TIMERS = 16,
	parameter int PRESCALE    = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // fast_enables, slow_enables, read_bank, read_index, pad
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // read_value, pulses_10ms, pulses_100ms, pulses_1000ms, pad
);
	import ptb_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [TIMER_W-1:0] read_value;
	logic [PULSE_W-1:0] p10, p100, p1000;

	ptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptb_datapath #(
		.FAST_TIMERS (FAST_TIMERS),
		.SLOW_TIMERS (SLOW_TIMERS),
		.PRESCALE    (PRESCALE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_mode       (s_tuser),
		.in_fast_en    (s_tdata[15:0]),
		.in_slow_en    (s_tdata[31:16]),
		.in_bank       (s_tdata[32]),
		.in_index      (s_tdata[36:33]),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.read_value    (read_value),
		.pulses_10ms   (p10),
		.pulses_100ms  (p100),
		.pulses_1000ms (p1000)
	);

	assign m_tdata = {4'b0, p1000, p100, p10, read_value};

endmodule

/* dv/plc_timer_bank_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_timer_bank_tb - self-checking bench for the soft-PLC timer bank
// Tick and read words go in through the slave stream. A behavioural copy of
// the prescaler chain, both timer banks and the pulse counters predicts each
// result word, and the result words are checked in order as they leave.
// Idling on both sides changes from phase to phase. A run of ticks at the
// end carries the 10 ms pulse counter into saturation.
// ----------------------------------------------------------------------------
module plc_timer_bank_tb;
	import ptb_pkg::*;

	localparam int N_FAST    = 16;
	localparam int N_SLOW    = 16;
	localparam int DIVIDE    = 10;
	localparam int SETTLE    = 4 + N_FAST + 1 + N_SLOW + 1 + 16;
	localparam int SAT_TICKS = DIVIDE * 130;

	// packed from the top down: read_value sits in the lowest bits
	typedef struct packed {
		logic [PULSE_W-1:0] pulses_1000ms;
		logic [PULSE_W-1:0] pulses_100ms;
		logic [PULSE_W-1:0] pulses_10ms;
		logic [TIMER_W-1:0] read_value;
	} timer_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // fast_enables, slow_enables, read_bank, read_index, pad
	logic        s_tuser;   // mode
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // read_value, pulses_10ms, pulses_100ms, pulses_1000ms, pad

	logic [TIMER_W-1:0] fast_cnt [N_FAST];
	logic [TIMER_W-1:0] slow_cnt [N_SLOW];
	logic [PRE_W-1:0]   ms_pre, tenms_pre, hundredms_pre;
	logic [PULSE_W-1:0] pulse_cnt [3];
	logic [EN_W-1:0]    fast_mask, slow_mask;
	timer_word_t        due_words [$];
	int                 mismatches = 0;
	int                 tx_gap_pct = 0;
	int                 rx_stall_pct = 0;
	int                 ticks_sent = 0;

	plc_timer_bank uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [TIMER_W-1:0] timer_next(input logic [TIMER_W-1:0] v,
			input logic en);
		if (!en)
			return '0;
		return (v == TIMER_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [EN_W-1:0] pick_mask();
		case ($urandom_range(3))
			0: return '1;
			1: return '0;
			2: return EN_W'(1) << $urandom_range(EN_W - 1);
			default: return EN_W'($urandom);
		endcase
	endfunction

	task automatic predict_word(input logic mode, input logic [EN_W-1:0] fen,
			input logic [EN_W-1:0] sen, input logic bank, input logic [IDX_W-1:0] idx);
		timer_word_t w;
		if (mode == MODE_TICK) begin
			if (ms_pre >= DIVIDE) begin
				for (int i = 0; i < N_FAST; i++)
					fast_cnt[i] = timer_next(fast_cnt[i], (i < EN_W) ? fen[i] : 1'b0);
				if (pulse_cnt[0] != PULSE_MAX)
					pulse_cnt[0]++;
				tenms_pre++;
				ms_pre = '0;
			end
			if (tenms_pre >= DIVIDE) begin
				for (int i = 0; i < N_SLOW; i++)
					slow_cnt[i] = timer_next(slow_cnt[i], (i < EN_W) ? sen[i] : 1'b0);
				if (pulse_cnt[1] != PULSE_MAX)
					pulse_cnt[1]++;
				hundredms_pre++;
				tenms_pre = '0;
			end
			if (hundredms_pre >= DIVIDE) begin
				if (pulse_cnt[2] != PULSE_MAX)
					pulse_cnt[2]++;
				hundredms_pre = '0;
			end
			ms_pre++;
		end
		w.read_value = '0;
		if (bank == BANK_FAST) begin
			if (idx < N_FAST)
				w.read_value = fast_cnt[idx];
		end else if (idx < N_SLOW) begin
			w.read_value = slow_cnt[idx];
		end
		w.pulses_10ms   = pulse_cnt[0];
		w.pulses_100ms  = pulse_cnt[1];
		w.pulses_1000ms = pulse_cnt[2];
		due_words.push_back(w);
	endtask

	task automatic send_word(input logic mode, input logic [EN_W-1:0] fen,
			input logic [EN_W-1:0] sen, input logic bank, input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'b000, idx, bank, sen, fen};
		do
			@(posedge clk);
		while (!s_tready);
		if (mode == MODE_TICK)
			ticks_sent++;
		predict_word(mode, fen, sen, bank, idx);
	endtask

	task automatic test_reset_reads();
		send_word(MODE_READ, '1, '1, BANK_FAST, '0);
		send_word(MODE_READ, '0, '0, BANK_FAST, '1);
		send_word(MODE_READ, '1, '0, BANK_SLOW, '0);
		send_word(MODE_READ, '0, '1, BANK_SLOW, '1);
	endtask

	// first 10 ms pass lands on the eleventh tick; a mixed mask then clears half
	task automatic test_first_passes();
		for (int i = 0; i < 11; i++)
			send_word(MODE_TICK, '1, '1, BANK_FAST, IDX_W'(i));
		for (int i = 0; i < 10; i++)
			send_word(MODE_TICK, 16'hA5A5, 16'h5A5A, i[0], 4'd1);
	endtask

	task automatic test_random_words(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) == 0)
				fast_mask = pick_mask();
			if ($urandom_range(99) == 0)
				slow_mask = pick_mask();
			if ($urandom_range(99) < 60)
				send_word(MODE_TICK, fast_mask, slow_mask, 1'($urandom_range(1)),
					IDX_W'($urandom_range(15)));
			else
				send_word(MODE_READ, EN_W'($urandom), EN_W'($urandom),
					1'($urandom_range(1)), IDX_W'($urandom_range(15)));
		end
	endtask

	// tops the tick total up past the 127th 10 ms pass
	task automatic test_pulse_saturation();
		while (ticks_sent < SAT_TICKS)
			send_word(MODE_TICK, '1, '1, 1'($urandom_range(1)), IDX_W'($urandom_range(15)));
		send_word(MODE_READ, '0, '0, BANK_FAST, 4'd7);
		send_word(MODE_READ, '0, '0, BANK_SLOW, 4'd7);
	endtask

	task automatic drain_and_report();
		int waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (due_words.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (due_words.size() != 0) begin
			mismatches++;
			$display("%0d result words never arrived", due_words.size());
		end
		if (mismatches == 0)
			$display("plc_timer_bank: match");
		else
			$display("plc_timer_bank: mismatch");
		$finish;
	endtask

	always @(posedge clk) begin : result_check
		timer_word_t got, want;
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[35:0];
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				want = due_words.pop_front();
				if (got.read_value !== want.read_value || got.pulses_10ms !== want.pulses_10ms
						|| got.pulses_100ms !== want.pulses_100ms
						|| got.pulses_1000ms !== want.pulses_1000ms) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word: exp value %0d p10 %0d p100 %0d p1000 %0d, got %0d %0d %0d %0d",
							want.read_value, want.pulses_10ms, want.pulses_100ms,
							want.pulses_1000ms, got.read_value, got.pulses_10ms,
							got.pulses_100ms, got.pulses_1000ms);
				end
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= MODE_TICK;
		s_tdata  <= '0;
		m_tready <= 1'b0;
		for (int i = 0; i < N_FAST; i++)
			fast_cnt[i] = '0;
		for (int i = 0; i < N_SLOW; i++)
			slow_cnt[i] = '0;
		for (int i = 0; i < 3; i++)
			pulse_cnt[i] = '0;
		ms_pre        = '0;
		tenms_pre     = '0;
		hundredms_pre = '0;
		fast_mask     = '1;
		slow_mask     = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_pct   = 9;
		rx_stall_pct = 83;
		test_reset_reads();
		test_first_passes();
		test_random_words(250);

		tx_gap_pct   = 83;
		rx_stall_pct = 9;
		test_random_words(250);

		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		test_random_words(250);
		test_pulse_saturation();

		drain_and_report();
	end

	initial begin
		#20_000_000;
		$display("plc_timer_bank: mismatch");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ptb_pkg.sv
hw/rtl/ptb_ram.sv
hw/rtl/ptb_ctrl.sv
hw/rtl/ptb_datapath.sv
hw/rtl/plc_timer_bank.sv
dv/plc_timer_bank_tb.sv
